// ----- sv/pkst_pkg.sv -----
// Package for the pid keyed slot table: field widths, status and operation
// codes, the controller state type and the structs passed between modules.
// No dependencies.
package pkst_pkg;

   localparam int PID_W = 32;
   localparam int TIME_W = 64;
   localparam int DATA_W = 64;
   localparam int STATUS_W = 3;
   localparam int SLOT_FIELD_W = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index is paddr[2]; only index zero exists.
   localparam logic CSR_IDX_ENABLED = 1'b0;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_UPDATED = 3'd0,
      STAT_FILLED  = 3'd1,
      STAT_EVICTED = 3'd2,
      STAT_HIT     = 3'd3,
      STAT_MISS    = 3'd4,
      STAT_IGNORED = 3'd5,
      STAT_NOWRITE = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctrl_type;

   typedef struct packed {
      logic match;
      logic empty;
      logic oldest;
   } scan_flags_type;

endpackage

// ----- sv/pkst_if.sv -----
// Handshake channels of the pid keyed slot table: the request channel and
// the response channel, each with valid, ready and its payload fields.
// Depends on pkst_pkg for the field widths.
interface pkst_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [pkst_pkg::PID_W-1:0]   pid;
   logic [pkst_pkg::TIME_W-1:0]  time_now;
   logic [pkst_pkg::DATA_W-1:0]  payload;

   modport source (output valid, operation, pid, time_now, payload, input ready);
   modport sink (input valid, operation, pid, time_now, payload, output ready);
endinterface

interface pkst_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pkst_pkg::STATUS_W-1:0]      status;
   logic [pkst_pkg::SLOT_FIELD_W-1:0]  slot;
   logic [pkst_pkg::DATA_W-1:0]        read_payload;

   modport source (output valid, status, slot, read_payload, input ready);
   modport sink (input valid, status, slot, read_payload, output ready);
endinterface

// ----- sv/pkst_cell.sv -----
// One table entry of the rotating slot chain: valid mark, pid, timestamp and
// payload. It takes its neighbor's entry on a shift or new data on a write.
// Depends on pkst_pkg.
module pkst_cell #(
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pkst_pkg::cell_ctrl_type       ctrl,
   input  logic                          nbr_valid,
   input  logic [pkst_pkg::PID_W-1:0]    nbr_pid,
   input  logic [pkst_pkg::TIME_W-1:0]   nbr_time,
   input  logic [PAYLOAD_BITS-1:0]       nbr_payload,
   input  logic [pkst_pkg::PID_W-1:0]    wr_pid,
   input  logic [pkst_pkg::TIME_W-1:0]   wr_time,
   input  logic [PAYLOAD_BITS-1:0]       wr_payload,
   output logic                          cur_valid,
   output logic [pkst_pkg::PID_W-1:0]    cur_pid,
   output logic [pkst_pkg::TIME_W-1:0]   cur_time,
   output logic [PAYLOAD_BITS-1:0]       cur_payload
);

   logic                          valid_ff, valid_in;
   logic [pkst_pkg::PID_W-1:0]    pid_ff, pid_in;
   logic [pkst_pkg::TIME_W-1:0]   time_ff, time_in;
   logic [PAYLOAD_BITS-1:0]       payload_ff, payload_in;

   always_comb begin
      valid_in   = valid_ff;
      pid_in     = pid_ff;
      time_in    = time_ff;
      payload_in = payload_ff;
      if (ctrl.write) begin
         valid_in   = 1'b1;
         pid_in     = wr_pid;
         time_in    = wr_time;
         payload_in = wr_payload;
      end else if (ctrl.shift) begin
         valid_in   = nbr_valid;
         pid_in     = nbr_pid;
         time_in    = nbr_time;
         payload_in = nbr_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff     <= pid_in;
      time_ff    <= time_in;
      payload_ff <= payload_in;
   end

   assign cur_valid   = valid_ff;
   assign cur_pid     = pid_ff;
   assign cur_time    = time_ff;
   assign cur_payload = payload_ff;

endmodule

// ----- sv/pkst_scan.sv -----
// Scan accumulator: watches the entry at the head of the chain once per
// rotation step and keeps the first pid match, first empty slot and oldest
// entry seen so far. Depends on pkst_pkg.
module pkst_scan #(
   parameter int SLOTS = 512,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                step,
   input  logic [$clog2(SLOTS)-1:0]            idx,
   input  logic [pkst_pkg::PID_W-1:0]          key,
   input  logic                                head_valid,
   input  logic [pkst_pkg::PID_W-1:0]          head_pid,
   input  logic [pkst_pkg::TIME_W-1:0]         head_time,
   input  logic [PAYLOAD_BITS-1:0]             head_payload,
   output pkst_pkg::scan_flags_type            flags,
   output logic [$clog2(SLOTS)-1:0]            match_idx,
   output logic [PAYLOAD_BITS-1:0]             match_payload,
   output logic [$clog2(SLOTS)-1:0]            empty_idx,
   output logic [$clog2(SLOTS)-1:0]            oldest_idx
);

   localparam int IDX_W = $clog2(SLOTS);

   pkst_pkg::scan_flags_type        flags_ff, flags_in;
   logic [IDX_W-1:0]                match_idx_ff, match_idx_in;
   logic [PAYLOAD_BITS-1:0]         match_payload_ff, match_payload_in;
   logic [IDX_W-1:0]                empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]                oldest_idx_ff, oldest_idx_in;
   logic [pkst_pkg::TIME_W-1:0]     oldest_time_ff, oldest_time_in;

   always_comb begin
      flags_in         = flags_ff;
      match_idx_in     = match_idx_ff;
      match_payload_in = match_payload_ff;
      empty_idx_in     = empty_idx_ff;
      oldest_idx_in    = oldest_idx_ff;
      oldest_time_in   = oldest_time_ff;
      if (start) begin
         flags_in       = '0;
         oldest_time_in = '1;
      end else if (step && !flags_ff.match) begin
         // Once a match is found the rest of the rotation only restores order.
         if (head_valid) begin
            if (head_pid == key) begin
               flags_in.match   = 1'b1;
               match_idx_in     = idx;
               match_payload_in = head_payload;
            end else if (head_time < oldest_time_ff) begin
               flags_in.oldest = 1'b1;
               oldest_idx_in   = idx;
               oldest_time_in  = head_time;
            end
         end else if (!flags_ff.empty) begin
            flags_in.empty = 1'b1;
            empty_idx_in   = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff     <= match_idx_in;
      match_payload_ff <= match_payload_in;
      empty_idx_ff     <= empty_idx_in;
      oldest_idx_ff    <= oldest_idx_in;
      oldest_time_ff   <= oldest_time_in;
   end

   assign flags         = flags_ff;
   assign match_idx     = match_idx_ff;
   assign match_payload = match_payload_ff;
   assign empty_idx     = empty_idx_ff;
   assign oldest_idx    = oldest_idx_ff;

endmodule

// ----- sv/pid_keyed_slot_table.sv -----
// Top level of the pid keyed slot table: a ring of SLOTS entry cells that
// rotates past a single scan unit, plus the controller and the APB register.
// Depends on pkst_pkg, pkst_if, pkst_cell and pkst_scan.
//
// Usage: request transfers on req_ch carry an update (store pid, timestamp
// and payload) or a lookup by pid; each gives exactly one response transfer
// on rsp_ch with a status, a slot index and the looked-up payload.
// A request walks the whole ring: the entries rotate one cell per cycle past
// the scan unit until every entry has been seen, then the finish state
// settles the result, does the write and loads the response register. A
// request that is ignored (disabled or pid zero) skips the walk and goes
// straight to the finish state.
// One request is in work at a time; a finished response sits in an output
// register, so the next request is accepted and walked while it waits. If
// the receiver stalls, the controller holds the next result until the output
// register frees up. Reset clears all valid marks and sets enabled to 1; the
// register at byte address 0 (enabled) is written through the APB port.
module pid_keyed_slot_table #(
   parameter int SLOTS = 512,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pkst_req_if.sink                             req_ch,
   pkst_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pkst_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pkst_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pkst_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Control registers.
   pkst_pkg::state_type              state_ff, state_in;
   logic [IDX_W-1:0]                 cnt_ff, cnt_in;
   logic                             enabled_ff, enabled_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Item and response payload registers.
   logic                             op_ff;
   logic                             ignore_ff;
   logic [pkst_pkg::PID_W-1:0]       key_ff;
   logic [pkst_pkg::TIME_W-1:0]      time_ff;
   logic [PAYLOAD_BITS-1:0]          data_ff;
   pkst_pkg::status_type             rsp_status_ff;
   logic [pkst_pkg::SLOT_FIELD_W-1:0] rsp_slot_ff;
   logic [pkst_pkg::DATA_W-1:0]      rsp_data_ff;

   // Ring of entry cells.
   logic                             cell_valid [SLOTS];
   logic [pkst_pkg::PID_W-1:0]       cell_pid [SLOTS];
   logic [pkst_pkg::TIME_W-1:0]      cell_time [SLOTS];
   logic [PAYLOAD_BITS-1:0]          cell_payload [SLOTS];
   pkst_pkg::cell_ctrl_type          cell_ctrl [SLOTS];

   // Scan results.
   pkst_pkg::scan_flags_type         flags;
   logic [IDX_W-1:0]                 match_idx;
   logic [PAYLOAD_BITS-1:0]          match_payload;
   logic [IDX_W-1:0]                 empty_idx;
   logic [IDX_W-1:0]                 oldest_idx;

   // Controller outputs and decision.
   logic                             req_accept;
   logic                             rsp_free;
   logic                             shift_en;
   logic                             scan_step;
   logic                             rsp_load;
   logic                             wr_en;
   pkst_pkg::status_type             dec_status;
   logic                             dec_write;
   logic                             dec_has_slot;
   logic [IDX_W-1:0]                 dec_idx;
   logic [pkst_pkg::DATA_W-1:0]      dec_data;
   logic [IDX_W+pkst_pkg::SLOT_FIELD_W-1:0] dec_idx_ext;
   logic [PAYLOAD_BITS+pkst_pkg::DATA_W-1:0] match_payload_ext;
   logic                             csr_write;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   // ---------------------------------------------------------------------
   // Cell ring: cell i takes the entry of cell i+1 on a shift, so the head
   // cell shows entry s at step s and the ring is back in order after
   // SLOTS steps.
   // ---------------------------------------------------------------------
   for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
      assign cell_ctrl[gi].shift = shift_en;
      assign cell_ctrl[gi].write = wr_en && (dec_idx == IDX_W'(gi));

      pkst_cell #(
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[gi]),
         .nbr_valid   (cell_valid[(gi + 1) % SLOTS]),
         .nbr_pid     (cell_pid[(gi + 1) % SLOTS]),
         .nbr_time    (cell_time[(gi + 1) % SLOTS]),
         .nbr_payload (cell_payload[(gi + 1) % SLOTS]),
         .wr_pid      (key_ff),
         .wr_time     (time_ff),
         .wr_payload  (data_ff),
         .cur_valid   (cell_valid[gi]),
         .cur_pid     (cell_pid[gi]),
         .cur_time    (cell_time[gi]),
         .cur_payload (cell_payload[gi])
      );
   end

   pkst_scan #(
      .SLOTS        (SLOTS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .start         (req_accept),
      .step          (scan_step),
      .idx           (cnt_ff),
      .key           (key_ff),
      .head_valid    (cell_valid[0]),
      .head_pid      (cell_pid[0]),
      .head_time     (cell_time[0]),
      .head_payload  (cell_payload[0]),
      .flags         (flags),
      .match_idx     (match_idx),
      .match_payload (match_payload),
      .empty_idx     (empty_idx),
      .oldest_idx    (oldest_idx)
   );

   // ---------------------------------------------------------------------
   // Result decision after the walk.
   // ---------------------------------------------------------------------
   assign match_payload_ext = {{pkst_pkg::DATA_W{1'b0}}, match_payload};

   always_comb begin
      dec_status   = pkst_pkg::STAT_IGNORED;
      dec_write    = 1'b0;
      dec_has_slot = 1'b0;
      dec_idx      = match_idx;
      dec_data     = '0;
      if (ignore_ff) begin
         dec_status = pkst_pkg::STAT_IGNORED;
      end else if (op_ff == pkst_pkg::OP_LOOKUP) begin
         if (flags.match) begin
            dec_status   = pkst_pkg::STAT_HIT;
            dec_has_slot = 1'b1;
            dec_data     = match_payload_ext[pkst_pkg::DATA_W-1:0];
         end else begin
            dec_status = pkst_pkg::STAT_MISS;
         end
      end else if (flags.match) begin
         dec_status   = pkst_pkg::STAT_UPDATED;
         dec_write    = 1'b1;
         dec_has_slot = 1'b1;
      end else if (flags.empty) begin
         dec_status   = pkst_pkg::STAT_FILLED;
         dec_write    = 1'b1;
         dec_has_slot = 1'b1;
         dec_idx      = empty_idx;
      end else if (flags.oldest) begin
         dec_status   = pkst_pkg::STAT_EVICTED;
         dec_write    = 1'b1;
         dec_has_slot = 1'b1;
         dec_idx      = oldest_idx;
      end else begin
         dec_status = pkst_pkg::STAT_NOWRITE;
      end
   end

   assign dec_idx_ext = {{pkst_pkg::SLOT_FIELD_W{1'b0}}, dec_idx};

   // ---------------------------------------------------------------------
   // Controller.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pkst_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (!enabled_ff || (req_ch.pid == '0)) begin
                  state_in = pkst_pkg::ST_FINISH;
               end else begin
                  state_in = pkst_pkg::ST_SCAN;
               end
            end
         end
         pkst_pkg::ST_SCAN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = pkst_pkg::ST_FINISH;
            end
         end
         pkst_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = pkst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pkst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      shift_en     = 1'b0;
      scan_step    = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         pkst_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         pkst_pkg::ST_SCAN: begin
            shift_en  = 1'b1;
            scan_step = 1'b1;
         end
         pkst_pkg::ST_FINISH: begin
            rsp_load = rsp_free;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   assign wr_en = rsp_load && dec_write;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_accept) begin
         cnt_in = '0;
      end else if (scan_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration register; writes must arrive only while the table is idle (not enforced here).
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      enabled_in = enabled_ff;
      if (csr_write && (csr_paddr[2] == pkst_pkg::CSR_IDX_ENABLED)) begin
         enabled_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == pkst_pkg::CSR_IDX_ENABLED) begin
         csr_prdata = {{(pkst_pkg::CSR_DATA_W-1){1'b0}}, enabled_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pkst_pkg::ST_IDLE;
         cnt_ff       <= '0;
         enabled_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= req_ch.operation;
         ignore_ff <= !enabled_ff || (req_ch.pid == '0);
         key_ff    <= req_ch.pid;
         time_ff   <= req_ch.time_now;
         data_ff   <= req_ch.payload[PAYLOAD_BITS-1:0];
      end
      if (rsp_load) begin
         rsp_status_ff <= dec_status;
         rsp_slot_ff   <= dec_has_slot ? dec_idx_ext[pkst_pkg::SLOT_FIELD_W-1:0] : '0;
         rsp_data_ff   <= dec_data;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.slot         = rsp_slot_ff;
   assign rsp_ch.read_payload = rsp_data_ff;

endmodule
